// ----- hw/rtl/sorted_priority_job_queue_top_assert.svh -----
// Assertion macros for the sorted priority job queue.
`ifndef SORTED_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPJQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/spjq_pkg.sv -----
// Types and constants shared by the sorted priority job queue.
package spjq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;
   localparam int PID_W       = 32;
   localparam int JID_W       = 32;
   localparam int PRI_W       = 16;

   typedef enum logic [1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_DEQUEUE = 2'd1,
      MODE_PEEK    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_ZERO_PRI = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRI_W-1:0] pri;
      logic [PID_W-1:0] pid;
      logic [JID_W-1:0] jid;
   } entry_type;

   // Broadcast to every cell for one transaction.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } op_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic      valid;
      logic      greater;
      entry_type entry;
   } link_type;

   // Sits left of the head cell: the head takes the new job whenever it shifts.
   localparam link_type HEAD_LINK = '{valid: 1'b1, greater: 1'b0, entry: '0};
   // Sits right of the last cell: an empty slot.
   localparam link_type TAIL_LINK = '{valid: 1'b0, greater: 1'b1, entry: '0};

endpackage

// ----- hw/rtl/spjq_cell.sv -----
// One slot of the sorted shift-register queue.
module spjq_cell (
   input  logic              clock,
   input  logic              reset,
   input  spjq_pkg::op_type   op,
   input  spjq_pkg::link_type left_link,
   input  spjq_pkg::link_type right_link,
   output spjq_pkg::link_type own_link
);
   import spjq_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      greater;

   assign greater = !valid_ff || (op.new_entry.pri < entry_ff.pri);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (op.insert && greater) begin
         valid_in = left_link.valid;
         entry_in = left_link.greater ? left_link.entry : op.new_entry;
      end else if (op.remove) begin
         valid_in = right_link.valid;
         entry_in = right_link.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign own_link.valid   = valid_ff;
   assign own_link.greater = greater;
   assign own_link.entry   = entry_ff;

endmodule

// ----- hw/rtl/sorted_priority_job_queue_top.sv -----
// Top level of the sorted priority job queue: cell chain, count and response register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | mode, new_pid, new_job_id, new_priority
//   rsp     | out       | rsp_valid / rsp_ready | status, head_pid, head_job_id,
//           |           |                       | head_priority, occupancy
//
// One transaction per cycle while req_ready is high: every cell compares and shifts in the accept cycle,
// and the response appears in the next cycle from the output register.
// The response register frees in the cycle it is taken, so req_ready drops only
// while a response waits and rsp_ready is low.
// Synchronous reset empties the queue.
module sorted_priority_job_queue_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [spjq_pkg::PID_W-1:0]   req_new_pid,
   input  logic [spjq_pkg::JID_W-1:0]   req_new_job_id,
   input  logic [spjq_pkg::PRI_W-1:0]   req_new_priority,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [spjq_pkg::PID_W-1:0]   rsp_head_pid,
   output logic [spjq_pkg::JID_W-1:0]   rsp_head_job_id,
   output logic [spjq_pkg::PRI_W-1:0]   rsp_head_priority,
   output logic [spjq_pkg::OCC_W-1:0]   rsp_occupancy
);
   import spjq_pkg::*;

   logic             accept;
   logic             full, empty;
   op_type           op;
   link_type         link [QUEUE_DEPTH];
   logic [CNT_W-1:0] held_count_ff, held_count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   entry_type        head_ff, head_in;
   logic [OCC_W-1:0] occupancy_ff, occupancy_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (held_count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (held_count_ff == '0);

   always_comb begin
      op.new_entry.pri = req_new_priority;
      op.new_entry.pid = req_new_pid;
      op.new_entry.jid = req_new_job_id;
      op.insert     = 1'b0;
      op.remove     = 1'b0;
      status_in     = ST_OK;
      head_in       = '0;
      held_count_in = held_count_ff;
      case (req_mode)
         MODE_ENQUEUE: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (req_new_priority == '0) begin
               status_in = ST_ZERO_PRI;
            end else begin
               op.insert     = accept;
               held_count_in = held_count_ff + CNT_W'(1);
            end
         end
         MODE_DEQUEUE, MODE_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               head_in = link[0].entry;
               if (req_mode == MODE_DEQUEUE) begin
                  op.remove     = accept;
                  held_count_in = held_count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
      occupancy_in = OCC_W'(held_count_in);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      link_type left_link, right_link;
      if (i == 0) begin : g_head
         assign left_link = HEAD_LINK;
      end else begin : g_mid_left
         assign left_link = link[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_link = TAIL_LINK;
      end else begin : g_mid_right
         assign right_link = link[i+1];
      end
      spjq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .left_link  (left_link),
         .right_link (right_link),
         .own_link   (link[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            held_count_ff <= held_count_in;
         end
      end
      if (accept) begin
         status_ff    <= status_in;
         head_ff      <= head_in;
         occupancy_ff <= occupancy_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_pid      = head_ff.pid;
   assign rsp_head_job_id   = head_ff.jid;
   assign rsp_head_priority = head_ff.pri;
   assign rsp_occupancy     = occupancy_ff;

`include "sorted_priority_job_queue_top_assert.svh"

   `SPJQ_ASSERT_NOW(a_head_valid, 1'b1, link[0].valid == !empty, "head slot disagrees with count")
   `SPJQ_ASSERT_NOW(a_head_sorted, link[1].valid, link[0].entry.pri <= link[1].entry.pri, "slots out of order")
   `SPJQ_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready, "request taken over a waiting response")
   `SPJQ_ASSERT_NEXT(a_insert_count, op.insert, held_count_ff == CNT_W'($past(held_count_ff) + CNT_W'(1)), "insert did not grow count")

endmodule

// ----- bench/sorted_priority_job_queue_checker.sv -----
// Checker for the sorted priority job queue: predicts each response and compares it.
module sorted_priority_job_queue_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [spjq_pkg::PID_W-1:0]   req_new_pid,
   input  logic [spjq_pkg::JID_W-1:0]   req_new_job_id,
   input  logic [spjq_pkg::PRI_W-1:0]   req_new_priority,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [1:0]                   rsp_status,
   input  logic [spjq_pkg::PID_W-1:0]   rsp_head_pid,
   input  logic [spjq_pkg::JID_W-1:0]   rsp_head_job_id,
   input  logic [spjq_pkg::PRI_W-1:0]   rsp_head_priority,
   input  logic [spjq_pkg::OCC_W-1:0]   rsp_occupancy,
   output int                           fault_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import spjq_pkg::*;

   typedef struct {
      status_type       status;
      logic [PID_W-1:0] pid;
      logic [JID_W-1:0] jid;
      logic [PRI_W-1:0] pri;
      logic [OCC_W-1:0] occ;
   } queue_outcome_type;

   entry_type         job_slot [QUEUE_DEPTH];
   int                held_jobs = 0;
   int                mismatches = 0;
   int                awaited_count = 0;
   queue_outcome_type awaited_outcomes [$];

   assign fault_count = mismatches;
   assign outstanding = awaited_count;

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic queue_outcome_type serve_request(logic [1:0] mode,
                                                       logic [PID_W-1:0] pid,
                                                       logic [JID_W-1:0] jid,
                                                       logic [PRI_W-1:0] pri);
      queue_outcome_type res;
      int                pos;
      entry_type         fresh;
      res.status = ST_OK;
      res.pid    = '0;
      res.jid    = '0;
      res.pri    = '0;
      if (mode == MODE_ENQUEUE) begin
         if (held_jobs >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else if (pri == '0) begin
            res.status = ST_ZERO_PRI;
         end else begin
            // place after every held job of equal or smaller priority number
            pos = held_jobs;
            for (int i = 0; i < held_jobs; i++) begin
               if (pri < job_slot[i].pri) begin
                  pos = i;
                  break;
               end
            end
            for (int i = held_jobs; i > pos; i--) job_slot[i] = job_slot[i-1];
            fresh.pri = pri;
            fresh.pid = pid;
            fresh.jid = jid;
            job_slot[pos] = fresh;
            held_jobs++;
         end
      end else if (mode == MODE_DEQUEUE || mode == MODE_PEEK) begin
         if (held_jobs == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.pid = job_slot[0].pid;
            res.jid = job_slot[0].jid;
            res.pri = job_slot[0].pri;
            if (mode == MODE_DEQUEUE) begin
               for (int i = 0; i + 1 < held_jobs; i++) job_slot[i] = job_slot[i+1];
               held_jobs--;
               job_slot[held_jobs] = '0;
            end
         end
      end
      res.occ = OCC_W'(held_jobs);
      return res;
   endfunction

   always @(posedge clock) begin
      queue_outcome_type want;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) job_slot[i] = '0;
         held_jobs = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("head_pid", want.pid, rsp_head_pid);
               check_field("head_job_id", want.jid, rsp_head_job_id);
               check_field("head_priority", want.pri, rsp_head_priority);
               check_field("occupancy", want.occ, rsp_occupancy);
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(serve_request(req_mode, req_new_pid, req_new_job_id,
                                                     req_new_priority));
      end
      awaited_count <= awaited_outcomes.size();
   end

endmodule

// ----- bench/sorted_priority_job_queue_top_tb.sv -----
// Testbench top for the sorted priority job queue: clock, reset, stimulus and verdict.
module sorted_priority_job_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spjq_pkg::*;

   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam int         ITEMS_PER_PHASE = 540;
   localparam int         BLOCK_ITEMS     = 32;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         STALL_LIMIT     = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = '0;
   logic [PID_W-1:0]   req_new_pid = '0;
   logic [JID_W-1:0]   req_new_job_id = '0;
   logic [PRI_W-1:0]   req_new_priority = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [PID_W-1:0]   rsp_head_pid;
   logic [JID_W-1:0]   rsp_head_job_id;
   logic [PRI_W-1:0]   rsp_head_priority;
   logic [OCC_W-1:0]   rsp_occupancy;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles = 0;
   int fault_count;
   int outstanding;

   sorted_priority_job_queue_top DUT (.*);

   sorted_priority_job_queue_checker u_check (.*);

   always #2 clock = ~clock;

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_job(input logic [1:0] mode, input logic [PID_W-1:0] pid,
                           input logic [JID_W-1:0] jid, input logic [PRI_W-1:0] pri);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_new_pid      <= pid;
      req_new_job_id   <= jid;
      req_new_priority <= pri;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [PRI_W-1:0] pick_priority();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return PRI_W'($urandom_range(8, 1));
      if (roll < 85) return PRI_W'($urandom);
      if (roll < 92) return '0;
      if (roll < 96) return '1;
      return PRI_W'(1);
   endfunction

   task automatic run_random(input int count);
      int         sent;
      int         block_left;
      int         enq_pct;
      int         deq_pct;
      int         roll;
      logic [1:0] mode;
      sent       = 0;
      block_left = 0;
      while (sent < count) begin
         if (block_left == 0) begin
            // bias the mix per block to fill, drain or churn the queue
            case ($urandom_range(2))
               0: begin
                  enq_pct = 72;
                  deq_pct = 15;
               end
               1: begin
                  enq_pct = 20;
                  deq_pct = 62;
               end
               default: begin
                  enq_pct = 45;
                  deq_pct = 40;
               end
            endcase
            block_left = BLOCK_ITEMS;
         end
         roll = $urandom_range(99);
         if (roll < enq_pct) mode = MODE_ENQUEUE;
         else if (roll < enq_pct + deq_pct) mode = MODE_DEQUEUE;
         else if (roll < 97) mode = MODE_PEEK;
         else mode = MODE_UNUSED;
         send_job(mode, $urandom, $urandom, pick_priority());
         if (mode != MODE_UNUSED) begin
            sent++;
            block_left--;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 47;

      send_job(MODE_PEEK, '1, '1, '1);
      send_job(MODE_DEQUEUE, '1, '1, '1);
      send_job(MODE_ENQUEUE, '1, '1, '0);
      send_job(MODE_ENQUEUE, '1, '1, '1);
      send_job(MODE_ENQUEUE, '0, '0, PRI_W'(1));
      send_job(MODE_ENQUEUE, 32'h1111_0001, 32'hA5A5_0001, PRI_W'(5));
      send_job(MODE_ENQUEUE, 32'h1111_0002, 32'hA5A5_0002, PRI_W'(5));
      send_job(MODE_ENQUEUE, 32'h1111_0003, 32'hA5A5_0003, PRI_W'(5));
      send_job(MODE_PEEK, '0, '0, '0);
      for (int k = 0; k < 11; k++)
         send_job(MODE_ENQUEUE, $urandom, $urandom,
                  (k % 3 == 0) ? PRI_W'(5) : (k == 10) ? '1 : PRI_W'(k + 2));
      send_job(MODE_ENQUEUE, '1, '1, '0);
      send_job(MODE_ENQUEUE, $urandom, $urandom, PRI_W'(3));
      send_job(MODE_UNUSED, '1, '1, '1);
      send_job(MODE_DEQUEUE, '0, '0, '0);
      send_job(MODE_PEEK, '0, '0, '0);

      run_random(ITEMS_PER_PHASE);

      send_idle_pct = 47;
      recv_idle_pct = 37;
      run_random(ITEMS_PER_PHASE);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(ITEMS_PER_PHASE);

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/spjq_pkg.sv
hw/rtl/spjq_cell.sv
hw/rtl/sorted_priority_job_queue_top.sv
bench/sorted_priority_job_queue_checker.sv
bench/sorted_priority_job_queue_top_tb.sv
